@@ src/dsw_pkg.sv @@
// ----------------------------------------------------------------------------
// dsw_pkg
// Shared types and codes for the delay-and-sum waveform synthesizer.
// ----------------------------------------------------------------------------
package dsw_pkg;

	localparam int ELEM_W     = 6;
	localparam int TIME_W     = 12;
	localparam int SAMPLE_W   = 16;
	localparam int AMP_W      = 16;
	localparam int FRAC_W     = 12;
	localparam int ECOUNT_W   = 7;
	localparam int SCOUNT_W   = 13;
	localparam int DSTEP_W    = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	// input mode field
	localparam logic [1:0] MODE_RECORD = 2'd0;
	localparam logic [1:0] MODE_STEER  = 2'd1;
	localparam logic [1:0] MODE_MEAN   = 2'd2;
	localparam logic [1:0] MODE_CLEAR  = 2'd3;

	// queued operations
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_SYNTH = 2'd1;
	localparam logic [1:0] OP_AVG   = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_STEP    = 2'd2;

	typedef struct packed {
		logic [1:0]                 op;
		logic [ELEM_W-1:0]          element;
		logic [TIME_W-1:0]          time_index;
		logic signed [SAMPLE_W-1:0] sample;
	} cmd_t;

endpackage

@@ src/dsw_fifo.sv @@
// ----------------------------------------------------------------------------
// dsw_fifo
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module dsw_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dsw_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output dsw_pkg::cmd_t pop_cmd
);

	dsw_pkg::cmd_t entry_q [2];
	logic          wptr_q;
	logic          rptr_q;
	logic [1:0]    cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign pop_cmd = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ src/dsw_front.sv @@
// ----------------------------------------------------------------------------
// dsw_front
// Input stage: accepts items, classifies them and drops out-of-range records.
// ----------------------------------------------------------------------------
module dsw_front #(
	parameter int MAX_ELEMENTS = 64,
	parameter int MAX_SAMPLES  = 4096
) (
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            mode,
	input  logic [dsw_pkg::ELEM_W-1:0]            element,
	input  logic [dsw_pkg::TIME_W-1:0]            time_index,
	input  logic signed [dsw_pkg::SAMPLE_W-1:0]   sample,
	input  logic                                  q_full,
	input  logic                                  hold,
	output logic                                  push,
	output dsw_pkg::cmd_t                         push_cmd
);

	logic in_range;
	logic keep;

	assign in_range = (32'(element) < MAX_ELEMENTS) && (32'(time_index) < MAX_SAMPLES);
	assign in_ready = !q_full && !hold;

	always_comb begin
		push_cmd.element    = element;
		push_cmd.time_index = time_index;
		push_cmd.sample     = sample;
		keep                = 1'b1;
		unique case (mode)
			dsw_pkg::MODE_RECORD: begin
				push_cmd.op = dsw_pkg::OP_WRITE;
				keep        = in_range;
			end
			dsw_pkg::MODE_STEER: push_cmd.op = dsw_pkg::OP_SYNTH;
			dsw_pkg::MODE_MEAN:  push_cmd.op = dsw_pkg::OP_AVG;
			dsw_pkg::MODE_CLEAR: push_cmd.op = dsw_pkg::OP_CLEAR;
			default:             push_cmd.op = dsw_pkg::OP_CLEAR;
		endcase
	end

	assign push = in_valid && in_ready && keep;

endmodule

@@ src/dsw_div.sv @@
// ----------------------------------------------------------------------------
// dsw_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dsw_div #(
	parameter int NW = 24,
	parameter int DW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int CNTW = $clog2(NW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [NW-1:0]   quo_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   den_q;
	logic [DW:0]     rem_sh;
	logic            ge;
	logic [DW:0]     rem_sub;

	assign rem_sh  = {rem_q, quo_q[NW-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign done    = done_q;
	assign quo     = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ src/dsw_back.sv @@
// ----------------------------------------------------------------------------
// dsw_back
// Execution engine: trace store, clear sweep, steered and mean interpolation
// loop, final divide and the output register.
// ----------------------------------------------------------------------------
module dsw_back #(
	parameter int MAX_ELEMENTS = 64,
	parameter int MAX_SAMPLES  = 4096,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_empty,
	input  dsw_pkg::cmd_t                        q_cmd,
	output logic                                 q_pop,
	input  logic [dsw_pkg::ECOUNT_W-1:0]         element_count,
	input  logic [dsw_pkg::SCOUNT_W-1:0]         sample_count,
	input  logic signed [dsw_pkg::DSTEP_W-1:0]   delay_step,
	output logic                                 init_busy,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [dsw_pkg::AMP_W-1:0]     amplitude
);

	localparam int EW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int TW    = $clog2(MAX_SAMPLES);
	localparam int AW    = EW + TW;
	localparam int DEPTH = 1 << AW;
	localparam int CW    = $clog2(MAX_ELEMENTS + 1);
	localparam int PA    = (CW + 18 > 24) ? CW + 18 : 24;
	localparam int PB    = (TW + 13 > PA) ? TW + 13 : PA;
	localparam int PW    = PB + 2;
	localparam int IW    = PW - dsw_pkg::FRAC_W;
	localparam int SB    = SAMPLE_BITS;
	localparam int ACCW  = SB + EW + 14;
	localparam int MW    = ACCW - dsw_pkg::FRAC_W;
	localparam int SW    = (MW + 1 > 17) ? MW + 1 : 17;
	localparam int SCW   = dsw_pkg::SCOUNT_W;

	localparam logic signed [31:0] SAT_HI = (32'sd1 <<< (SB - 1)) - 32'sd1;
	localparam logic signed [31:0] SAT_LO = -SAT_HI - 32'sd1;
	localparam logic signed [SW-1:0] AMP_HI = SW'(32767);
	localparam logic signed [SW-1:0] AMP_LO = SW'(-32768);

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_CLR   = 3'd2;
	localparam logic [2:0] S_SETUP = 3'd3;
	localparam logic [2:0] S_RUN   = 3'd4;
	localparam logic [2:0] S_DRAIN = 3'd5;
	localparam logic [2:0] S_DIV   = 3'd6;
	localparam logic [2:0] S_RES   = 3'd7;

	logic [2:0]                    state_q;
	logic [AW-1:0]                 clr_q;
	logic [dsw_pkg::TIME_W-1:0]    t_q;
	logic                          avg_q;
	logic [CW-1:0]                 n_q;
	logic [CW-1:0]                 g_q;
	logic [SCW-1:0]                lenm1_q;
	logic signed [PW-1:0]          ds_q;
	logic signed [PW-1:0]          p_q;
	logic signed [ACCW-1:0]        acc_q;
	logic                          neg_q;
	logic signed [dsw_pkg::AMP_W-1:0] res_q;
	logic                          out_valid_q;
	logic signed [dsw_pkg::AMP_W-1:0] amplitude_q;

	logic signed [SB-1:0]          mem [DEPTH];

	// interpolation pipeline
	logic                          v_s1;
	logic                          zero_s1;
	logic                          last_s1;
	logic [dsw_pkg::FRAC_W-1:0]    f_s1;
	logic signed [SB-1:0]          rd_a_s1;
	logic signed [SB-1:0]          rd_b_s1;
	logic                          v_s2;
	logic signed [SB+11:0]         base_s2;
	logic signed [SB+13:0]         prod_s2;

	// combinational
	logic                          we;
	logic [AW-1:0]                 waddr;
	logic signed [SB-1:0]          wdata;
	logic signed [31:0]            smp32;
	logic [AW-1:0]                 raddr_a;
	logic [AW-1:0]                 raddr_b;
	logic [CW-1:0]                 n_c;
	logic [SCW-1:0]                len_c;
	logic signed [dsw_pkg::DSTEP_W-1:0] ds_c;
	logic signed [CW+17:0]         off_prod;
	logic signed [PW-1:0]          p0_c;
	logic [IW-1:0]                 i_c;
	logic [TW-1:0]                 i1_c;
	logic                          over_c;
	logic                          last_c;
	logic signed [SB-1:0]          a_eff;
	logic [dsw_pkg::FRAC_W-1:0]    f_eff;
	logic signed [SB:0]            diff_c;
	logic [ACCW-1:0]               mag_c;
	logic                          drained;
	logic                          div_start;
	logic                          div_done;
	logic [MW-1:0]                 quo;
	logic signed [SW-1:0]          sq_c;
	logic signed [dsw_pkg::AMP_W-1:0] sat_c;

	assign init_busy = (state_q == S_INIT);
	assign q_pop     = (state_q == S_IDLE) && !q_empty;
	assign out_valid = out_valid_q;
	assign amplitude = amplitude_q;

	// record sample saturated to the stored width
	always_comb begin
		smp32 = 32'(q_cmd.sample);
		if (smp32 > SAT_HI) begin
			smp32 = SAT_HI;
		end else if (smp32 < SAT_LO) begin
			smp32 = SAT_LO;
		end
	end

	always_comb begin
		if (state_q == S_INIT || state_q == S_CLR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else begin
			we    = q_pop && (q_cmd.op == dsw_pkg::OP_WRITE);
			waddr = {EW'(q_cmd.element), TW'(q_cmd.time_index)};
			wdata = smp32[SB-1:0];
		end
	end

	// clamped counts and start position
	always_comb begin
		if (element_count == '0) begin
			n_c = CW'(1);
		end else if (32'(element_count) > MAX_ELEMENTS) begin
			n_c = CW'(MAX_ELEMENTS);
		end else begin
			n_c = CW'(element_count);
		end
		if (sample_count < SCW'(2)) begin
			len_c = SCW'(2);
		end else if (32'(sample_count) > MAX_SAMPLES) begin
			len_c = SCW'(MAX_SAMPLES);
		end else begin
			len_c = sample_count;
		end
		ds_c     = avg_q ? '0 : delay_step;
		off_prod = $signed({1'b0, n_c - CW'(1)}) * ds_c;
		// negative step mirrors the array: trace 0 gets the largest shift
		p0_c     = $signed(PW'({t_q, {dsw_pkg::FRAC_W{1'b0}}}))
			+ (ds_c[dsw_pkg::DSTEP_W-1] ? PW'(off_prod) : '0);
	end

	// read position of the current trace
	always_comb begin
		i_c     = p_q[PW-1:dsw_pkg::FRAC_W];
		i1_c    = i_c[TW-1:0] + TW'(1);
		over_c  = i_c > IW'(lenm1_q);
		last_c  = i_c == IW'(lenm1_q);
		raddr_a = {g_q[EW-1:0], i_c[TW-1:0]};
		raddr_b = {g_q[EW-1:0], i1_c};
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_a_s1 <= mem[raddr_a];
		rd_b_s1 <= mem[raddr_b];
	end

	// tap = 4096*a + f*(b-a); last sample uses a alone
	always_comb begin
		a_eff  = zero_s1 ? '0 : rd_a_s1;
		f_eff  = (zero_s1 || last_s1) ? '0 : f_s1;
		diff_c = $signed({rd_b_s1[SB-1], rd_b_s1}) - $signed({rd_a_s1[SB-1], rd_a_s1});
	end

	always_ff @(posedge clk) begin
		zero_s1 <= p_q[PW-1] || over_c;
		last_s1 <= last_c;
		f_s1    <= p_q[dsw_pkg::FRAC_W-1:0];
		base_s2 <= $signed({a_eff, {dsw_pkg::FRAC_W{1'b0}}});
		prod_s2 <= $signed({1'b0, f_eff}) * diff_c;
	end

	assign drained   = !v_s1 && !v_s2;
	assign div_start = (state_q == S_DRAIN) && drained;
	assign mag_c     = acc_q[ACCW-1] ? ACCW'(-acc_q) : ACCW'(acc_q);

	dsw_div #(
		.NW(MW),
		.DW(CW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (mag_c[ACCW-1:dsw_pkg::FRAC_W]),
		.den   (n_q),
		.done  (div_done),
		.quo   (quo)
	);

	always_comb begin
		sq_c = neg_q ? -$signed(SW'(quo)) : $signed(SW'(quo));
		if (sq_c > AMP_HI) begin
			sat_c = dsw_pkg::AMP_W'(AMP_HI);
		end else if (sq_c < AMP_LO) begin
			sat_c = dsw_pkg::AMP_W'(AMP_LO);
		end else begin
			sat_c = dsw_pkg::AMP_W'(sq_c);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				t_q   <= q_cmd.time_index;
				avg_q <= (q_cmd.op == dsw_pkg::OP_AVG);
			end
			S_SETUP: begin
				n_q     <= n_c;
				lenm1_q <= len_c - SCW'(1);
				ds_q    <= PW'(ds_c);
				p_q     <= p0_c;
				acc_q   <= '0;
			end
			S_RUN: begin
				p_q <= p_q - ds_q;
			end
			S_DRAIN: begin
				neg_q <= acc_q[ACCW-1];
			end
			S_DIV: begin
				res_q <= sat_c;
			end
			default: begin
			end
		endcase
		if (v_s2) begin
			acc_q <= acc_q + ACCW'(base_s2) + ACCW'(prod_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			clr_q       <= '0;
			g_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			amplitude_q <= '0;
		end else begin
			v_s1 <= (state_q == S_RUN);
			v_s2 <= v_s1;
			if (state_q == S_RES && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT, S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_pop) begin
						unique case (q_cmd.op)
							dsw_pkg::OP_WRITE: state_q <= S_IDLE;
							dsw_pkg::OP_CLEAR: begin
								clr_q   <= '0;
								state_q <= S_CLR;
							end
							default: state_q <= S_SETUP;
						endcase
					end
				end
				S_SETUP: begin
					g_q     <= '0;
					state_q <= S_RUN;
				end
				S_RUN: begin
					g_q <= g_q + CW'(1);
					if (g_q == n_q - CW'(1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (drained) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_RES;
					end
				end
				S_RES: begin
					if (!out_valid_q || out_ready) begin
						amplitude_q <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ src/delay_and_sum_waveform_synth.sv @@
// ----------------------------------------------------------------------------
// delay_and_sum_waveform_synth
// Delay-and-sum synthesizer over recorded per-element traces.
// ----------------------------------------------------------------------------
// Items enter on in_valid/in_ready and go into a two-entry command queue; a
// back end executes them one at a time. Results leave on out_valid/out_ready
// from an output register, so the next item is taken while a result waits.
// Registers are written on cfg_valid/cfg_ready (always ready); the user must
// write them only while idle, which the block does not enforce. A record item
// is written to the store as it is popped and gives no result. A steered or
// mean item walks the elements, one trace per cycle with two store reads each,
// then runs a bit-serial divide with MW = SAMPLE_BITS + log2(MAX_ELEMENTS) + 2
// quotient bits. A clear item sweeps the whole store, MAX_ELEMENTS *
// MAX_SAMPLES words (each rounded up to a power of two), one word per cycle.
// After reset the same sweep runs, and no item is taken until it ends. A
// stalled receiver holds the result register; the back end then waits with
// its next result, and the queue fills behind it.
// ----------------------------------------------------------------------------
module delay_and_sum_waveform_synth #(
	parameter int MAX_ELEMENTS = 64,
	parameter int MAX_SAMPLES  = 4096,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            mode,
	input  logic [dsw_pkg::ELEM_W-1:0]            element,
	input  logic [dsw_pkg::TIME_W-1:0]            time_index,
	input  logic signed [dsw_pkg::SAMPLE_W-1:0]   sample,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [dsw_pkg::AMP_W-1:0]      amplitude,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [dsw_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [dsw_pkg::CFG_DATA_W-1:0]        cfg_data
);

	logic [dsw_pkg::ECOUNT_W-1:0]       element_count_q;
	logic [dsw_pkg::SCOUNT_W-1:0]       sample_count_q;
	logic signed [dsw_pkg::DSTEP_W-1:0] delay_step_q;

	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_empty;
	dsw_pkg::cmd_t push_cmd;
	dsw_pkg::cmd_t pop_cmd;
	logic          init_busy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q <= dsw_pkg::ECOUNT_W'(1);
			sample_count_q  <= dsw_pkg::SCOUNT_W'(4096);
			delay_step_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dsw_pkg::REG_ELEMENT_COUNT: element_count_q <= cfg_data[dsw_pkg::ECOUNT_W-1:0];
				dsw_pkg::REG_SAMPLE_COUNT:  sample_count_q  <= cfg_data[dsw_pkg::SCOUNT_W-1:0];
				dsw_pkg::REG_DELAY_STEP:    delay_step_q    <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

	dsw_front #(
		.MAX_ELEMENTS(MAX_ELEMENTS),
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.element   (element),
		.time_index(time_index),
		.sample    (sample),
		.q_full    (q_full),
		.hold      (init_busy),
		.push      (q_push),
		.push_cmd  (push_cmd)
	);

	dsw_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.pop_cmd (pop_cmd)
	);

	dsw_back #(
		.MAX_ELEMENTS(MAX_ELEMENTS),
		.MAX_SAMPLES (MAX_SAMPLES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_cmd        (pop_cmd),
		.q_pop        (q_pop),
		.element_count(element_count_q),
		.sample_count (sample_count_q),
		.delay_step   (delay_step_q),
		.init_busy    (init_busy),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.amplitude    (amplitude)
	);

`ifndef SYNTHESIS
	a_no_accept_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !in_ready)
		else $error("item accepted during store clear after reset");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("command pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> !q_pop)
		else $error("command popped from an empty queue");
`endif

endmodule
